@@ sv/csvtok_pkg.sv @@
`timescale 1ns / 1ps
// shared types, character codes and helpers for the csv integer token parser
// no dependencies; used by every module of the block

package csvtok_pkg;

  // character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_Q      = 8'h51;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // header tracking: 0..3 bytes matched, then past the header
  localparam int unsigned HDR_W = 3;
  localparam logic [HDR_W-1:0] HDR_IDLE = 3'd0;
  localparam logic [HDR_W-1:0] HDR_DONE = 3'd4;

  localparam int unsigned VAL_W = 16;
  localparam int unsigned IDX_W = 8;
  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  // conversion phase of the open token
  typedef enum logic [2:0] {
    PH_SPACE  = 3'b001,
    PH_DIGITS = 3'b010,
    PH_STOP   = 3'b100
  } phase_t;

  // one message byte as it moves from the input register to the core
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  // expected header byte at a given matched position
  function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
    logic [7:0] ch;
    begin
      unique case (pos)
        2'd0:    ch = CH_DOLLAR;
        2'd1:    ch = CH_R;
        2'd2:    ch = CH_Q;
        default: ch = CH_COMMA;
      endcase
      return ch;
    end
  endfunction

endpackage

@@ sv/csv_integer_token_parser_unit.sv @@
`timescale 1ns / 1ps
// top level of the csv integer token parser: input register followed by the core
// depends on csvtok_pkg, csvtok_in_stage and csvtok_core

// Parses a byte stream of comma-separated decimal integers, one byte per
// transaction on the in_ channel with in_tlast on the final byte of a message.
// An optional leading "$RQ," header is skipped; ',' and '*' and the final byte
// close a token, and each non-empty token is converted atoi style, wrapped to
// 16 bits, and sent on the out_ channel with its index in the message and
// out_tlast set when the final byte closed it. The block takes one byte every
// clock cycle unless out_tready stalls; a result becomes valid once its closing
// byte has passed the input register and the per-byte update has loaded the
// result register, and a stall on out_tready holds the input side once both
// registers are full.

module csv_integer_token_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] token_value, [23:16] token_index
  output logic        out_tlast   // message_done
);

  csvtok_pkg::byte_item_t in_item;
  csvtok_pkg::byte_item_t stg_item;
  logic                   stg_valid;
  logic                   stg_ready;
  logic [csvtok_pkg::VAL_W-1:0] token_value;
  logic [csvtok_pkg::IDX_W-1:0] token_index;

  assign in_item.data = in_tdata;
  assign in_item.last = in_tlast;

  // input register
  csvtok_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .stg_valid (stg_valid),
    .stg_ready (stg_ready),
    .stg_item  (stg_item)
  );

  // parser core with result register
  csvtok_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stg_valid),
    .in_ready  (stg_ready),
    .in_item   (stg_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (token_value),
    .out_index (token_index),
    .out_done  (out_tlast)
  );

  assign out_tdata = {token_index, token_value};

endmodule

@@ sv/csvtok_in_stage.sv @@
`timescale 1ns / 1ps
// input register of the parser: holds one accepted byte until the core takes it
// depends on csvtok_pkg

module csvtok_in_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  csvtok_pkg::byte_item_t  in_item,
  output logic                    stg_valid,
  input  logic                    stg_ready,
  output csvtok_pkg::byte_item_t  stg_item
);

  logic                   valid_r;
  logic                   valid_nxt;
  csvtok_pkg::byte_item_t item_r;

  // register is free when empty or when the core takes it this cycle
  assign in_ready = !valid_r || stg_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign stg_valid = valid_r;
  assign stg_item  = item_r;

endmodule

@@ sv/csvtok_core.sv @@
`timescale 1ns / 1ps
// parser state, per-byte token conversion and result register
// depends on csvtok_pkg

module csvtok_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  csvtok_pkg::byte_item_t              in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [csvtok_pkg::VAL_W-1:0]        out_value,
  output logic [csvtok_pkg::IDX_W-1:0]        out_index,
  output logic                                out_done
);

  logic [csvtok_pkg::HDR_W-1:0] hdr_r, hdr_nxt;
  logic                         open_r, open_nxt;
  csvtok_pkg::phase_t           phase_r, phase_nxt;
  logic                         neg_r, neg_nxt;
  logic [csvtok_pkg::VAL_W-1:0] acc_r, acc_nxt;
  logic [csvtok_pkg::IDX_W-1:0] cnt_r, cnt_nxt;

  logic                         res_valid_r, res_valid_nxt;
  logic [csvtok_pkg::VAL_W-1:0] res_value_r, res_value;
  logic [csvtok_pkg::IDX_W-1:0] res_index_r;
  logic                         res_done_r;

  logic                         step_en;
  logic                         emit;
  logic                         in_hdr;
  logic                         is_digit;
  logic                         is_space;
  logic                         is_delim;
  logic [csvtok_pkg::VAL_W-1:0] digit_val;
  logic [csvtok_pkg::VAL_W-1:0] acc_x10;

  assign in_ready = !res_valid_r || out_ready;
  assign step_en  = in_valid && in_ready;

  // byte classes
  assign is_digit  = (in_item.data >= csvtok_pkg::CH_ZERO) && (in_item.data <= csvtok_pkg::CH_NINE);
  assign is_space  = (in_item.data == csvtok_pkg::CH_SPACE) ||
                     ((in_item.data >= csvtok_pkg::CH_TAB) && (in_item.data <= csvtok_pkg::CH_CR));
  assign is_delim  = (in_item.data == csvtok_pkg::CH_COMMA) ||
                     (in_item.data == csvtok_pkg::CH_STAR) || in_item.last;
  assign digit_val = {{(csvtok_pkg::VAL_W-4){1'b0}}, in_item.data[3:0]};

  // next state and result for one byte
  always_comb begin
    hdr_nxt   = hdr_r;
    open_nxt  = open_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    emit      = 1'b0;
    in_hdr    = 1'b0;
    res_value = '0;
    acc_x10   = '0;

    // header match
    if (hdr_r == csvtok_pkg::HDR_IDLE) begin
      if (in_item.data == csvtok_pkg::CH_DOLLAR && !in_item.last) begin
        hdr_nxt = csvtok_pkg::HDR_IDLE + 3'd1;
        in_hdr  = 1'b1;
      end else begin
        hdr_nxt = csvtok_pkg::HDR_DONE;
      end
    end else if (hdr_r < csvtok_pkg::HDR_DONE) begin
      if (!in_item.last && in_item.data == csvtok_pkg::hdr_byte(hdr_r[1:0])) begin
        hdr_nxt = hdr_r + 3'd1;
        in_hdr  = 1'b1;
      end else begin
        // broken header opens a token stopped at the dollar sign
        hdr_nxt   = csvtok_pkg::HDR_DONE;
        open_nxt  = 1'b1;
        phase_nxt = csvtok_pkg::PH_STOP;
        neg_nxt   = 1'b0;
        acc_nxt   = '0;
      end
    end

    // token close or conversion
    if (!in_hdr) begin
      if (is_delim) begin
        if (open_nxt) begin
          emit      = 1'b1;
          res_value = neg_nxt ? (~acc_nxt + 16'd1) : acc_nxt;
          if (cnt_r != csvtok_pkg::IDX_MAX) begin
            cnt_nxt = cnt_r + 8'd1;
          end
          open_nxt = 1'b0;
        end
      end else begin
        if (!open_nxt) begin
          open_nxt  = 1'b1;
          phase_nxt = csvtok_pkg::PH_SPACE;
          neg_nxt   = 1'b0;
          acc_nxt   = '0;
        end
        acc_x10 = {acc_nxt[12:0], 3'b000} + {acc_nxt[14:0], 1'b0};
        unique case (phase_nxt)
          csvtok_pkg::PH_SPACE: begin
            if (is_space) begin
              phase_nxt = csvtok_pkg::PH_SPACE;
            end else if (in_item.data == csvtok_pkg::CH_PLUS) begin
              phase_nxt = csvtok_pkg::PH_DIGITS;
            end else if (in_item.data == csvtok_pkg::CH_MINUS) begin
              neg_nxt   = 1'b1;
              phase_nxt = csvtok_pkg::PH_DIGITS;
            end else if (is_digit) begin
              acc_nxt   = digit_val;
              phase_nxt = csvtok_pkg::PH_DIGITS;
            end else begin
              phase_nxt = csvtok_pkg::PH_STOP;
            end
          end
          csvtok_pkg::PH_DIGITS: begin
            if (is_digit) begin
              acc_nxt = acc_x10 + digit_val;
            end else begin
              phase_nxt = csvtok_pkg::PH_STOP;
            end
          end
          csvtok_pkg::PH_STOP: begin
            phase_nxt = csvtok_pkg::PH_STOP;
          end
          default: begin
            phase_nxt = csvtok_pkg::PH_STOP;
          end
        endcase
      end
    end

    // final byte returns everything to the message start
    if (in_item.last) begin
      hdr_nxt   = csvtok_pkg::HDR_IDLE;
      open_nxt  = 1'b0;
      phase_nxt = csvtok_pkg::PH_SPACE;
      neg_nxt   = 1'b0;
      acc_nxt   = '0;
      cnt_nxt   = '0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r   <= csvtok_pkg::HDR_IDLE;
      open_r  <= 1'b0;
      phase_r <= csvtok_pkg::PH_SPACE;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      cnt_r   <= '0;
    end else if (step_en) begin
      hdr_r   <= hdr_nxt;
      open_r  <= open_nxt;
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // result register valid
  always_comb begin
    res_valid_nxt = res_valid_r;
    if (in_ready) begin
      res_valid_nxt = step_en && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (step_en && emit) begin
      res_value_r <= res_value;
      res_index_r <= cnt_r;
      res_done_r  <= in_item.last;
    end
  end

  assign out_valid = res_valid_r;
  assign out_value = res_value_r;
  assign out_index = res_index_r;
  assign out_done  = res_done_r;

  // a stalled result blocks the next byte
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !out_ready) |-> !step_en)
    else $error("byte consumed while result stalled");

  // the final byte clears all message state
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && in_item.last) |=> (hdr_r == csvtok_pkg::HDR_IDLE && !open_r && cnt_r == '0))
    else $error("state not cleared after final byte");

  // token count only grows inside a message
  a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && !in_item.last) |=> (cnt_r >= $past(cnt_r)))
    else $error("token count went backwards");

  // header position stays within range
  a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_r <= csvtok_pkg::HDR_DONE)
    else $error("header position out of range");

  // a result taken from a final byte carries the done flag
  a_done_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && emit) |=> (res_valid_r && res_done_r == $past(in_item.last)))
    else $error("result done flag mismatch");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for csv_integer_token_parser_unit: byte stream in, tokens out
// depends on csvtok_pkg and the parser rtl; a token predictor class checks every result

module testbench;

  // one converted token as the block should report it
  typedef struct packed {
    logic [csvtok_pkg::VAL_W-1:0] value;
    logic [csvtok_pkg::IDX_W-1:0] index;
    logic                         done;
  } token_result_t;

  // tracks the parser state per accepted byte and holds the tokens still owed
  class csv_token_predictor;
    logic [csvtok_pkg::HDR_W-1:0] hdr_pos;
    bit                           tok_open;
    csvtok_pkg::phase_t           phase;
    bit                           negative;
    logic [csvtok_pkg::VAL_W-1:0] magnitude;
    logic [csvtok_pkg::IDX_W-1:0] count;
    logic [7:0]                   hdr_seq[4];
    token_result_t                expected_tokens[$];
    int                           errors;

    function new();
      hdr_seq = '{csvtok_pkg::CH_DOLLAR, csvtok_pkg::CH_R, csvtok_pkg::CH_Q,
                  csvtok_pkg::CH_COMMA};
      errors = 0;
      clear_message();
    endfunction

    function void clear_message();
      hdr_pos   = csvtok_pkg::HDR_IDLE;
      tok_open  = 1'b0;
      phase     = csvtok_pkg::PH_SPACE;
      negative  = 1'b0;
      magnitude = '0;
      count     = '0;
    endfunction

    function void open_token(csvtok_pkg::phase_t ph);
      tok_open  = 1'b1;
      phase     = ph;
      negative  = 1'b0;
      magnitude = '0;
    endfunction

    // atoi style conversion of one byte inside an open token
    function void convert_byte(logic [7:0] b);
      bit is_digit;
      is_digit = (b >= csvtok_pkg::CH_ZERO && b <= csvtok_pkg::CH_NINE);
      case (phase)
        csvtok_pkg::PH_SPACE: begin
          if (b == csvtok_pkg::CH_SPACE ||
              (b >= csvtok_pkg::CH_TAB && b <= csvtok_pkg::CH_CR)) begin
            phase = csvtok_pkg::PH_SPACE;
          end else if (b == csvtok_pkg::CH_PLUS) begin
            phase = csvtok_pkg::PH_DIGITS;
          end else if (b == csvtok_pkg::CH_MINUS) begin
            negative = 1'b1;
            phase    = csvtok_pkg::PH_DIGITS;
          end else if (is_digit) begin
            magnitude = 16'(b - csvtok_pkg::CH_ZERO);
            phase     = csvtok_pkg::PH_DIGITS;
          end else begin
            phase = csvtok_pkg::PH_STOP;
          end
        end
        csvtok_pkg::PH_DIGITS: begin
          if (is_digit) magnitude = magnitude * 16'd10 + 16'(b - csvtok_pkg::CH_ZERO);
          else phase = csvtok_pkg::PH_STOP;
        end
        default: ;
      endcase
    endfunction

    // called for every accepted input transaction
    function void note_byte(logic [7:0] b, logic last);
      token_result_t t;
      // header matching
      if (hdr_pos == csvtok_pkg::HDR_IDLE) begin
        if (b == csvtok_pkg::CH_DOLLAR && !last) begin
          hdr_pos = 3'd1;
          return;
        end
        hdr_pos = csvtok_pkg::HDR_DONE;
      end else if (hdr_pos < csvtok_pkg::HDR_DONE) begin
        if (!last && b == hdr_seq[hdr_pos[1:0]]) begin
          hdr_pos = hdr_pos + 3'd1;
          return;
        end
        // broken header: the bytes so far form a token that converts to zero
        hdr_pos = csvtok_pkg::HDR_DONE;
        open_token(csvtok_pkg::PH_STOP);
      end
      // delimiters and the final byte close a token
      if (b == csvtok_pkg::CH_COMMA || b == csvtok_pkg::CH_STAR || last) begin
        if (tok_open) begin
          t.value = negative ? -magnitude : magnitude;
          t.index = count;
          t.done  = last;
          expected_tokens.push_back(t);
          if (count != csvtok_pkg::IDX_MAX) count = count + 8'd1;
          tok_open = 1'b0;
        end
      end else begin
        if (!tok_open) open_token(csvtok_pkg::PH_SPACE);
        convert_byte(b);
      end
      if (last) clear_message();
    endfunction

    // called for every accepted result transaction
    function void check_token(logic [csvtok_pkg::VAL_W-1:0] value,
                              logic [csvtok_pkg::IDX_W-1:0] index, logic done);
      token_result_t e;
      if (expected_tokens.size() == 0) begin
        $error("unexpected token: token_value %0d token_index %0d message_done %0b",
               $signed(value), index, done);
        errors++;
        return;
      end
      e = expected_tokens.pop_front();
      if (value !== e.value) begin
        $error("token_value: expected %0d, actual %0d", $signed(e.value), $signed(value));
        errors++;
      end
      if (index !== e.index) begin
        $error("token_index: expected %0d, actual %0d", e.index, index);
        errors++;
      end
      if (done !== e.done) begin
        $error("message_done: expected %0b, actual %0b", e.done, done);
        errors++;
      end
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] byte_in
  logic        in_tlast   = 1'b0;   // end_of_message
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;           // [15:0] token_value, [23:16] token_index
  logic        out_tlast;           // message_done

  csv_token_predictor predictor;
  int gap_pct    = 0;
  int stall_pct  = 0;
  int bytes_sent = 0;
  string header_text = "$RQ,";

  csv_integer_token_parser_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random back-pressure on the result side
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // monitors for both channels
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) predictor.note_byte(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready)
      predictor.check_token(out_tdata[15:0], out_tdata[23:16], out_tlast);
  end

  // one input transaction, with an optional random gap in front
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (in_tready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit ends_message);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], ends_message && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] space_byte();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? csvtok_pkg::CH_SPACE : csvtok_pkg::CH_TAB + 8'(r);
  endfunction

  function automatic logic [7:0] digit_byte();
    return csvtok_pkg::CH_ZERO + 8'($urandom_range(9));
  endfunction

  // token body: white space, sign, digits and sometimes a stray byte
  task automatic send_token_body();
    int n;
    if ($urandom_range(7) == 0) return;
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) send_byte(space_byte(), 1'b0);
    case ($urandom_range(3))
      0:       send_byte(csvtok_pkg::CH_PLUS, 1'b0);
      1:       send_byte(csvtok_pkg::CH_MINUS, 1'b0);
      default: ;
    endcase
    n = ($urandom_range(7) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 5);
    repeat (n) send_byte(digit_byte(), 1'b0);
    if ($urandom_range(7) == 0) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  // mostly well-formed messages, some broken headers, some raw noise
  task automatic send_random_message();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 15) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)), i == n - 1);
      return;
    end
    if (kind < 30) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) send_byte(header_text[i], 1'b0);
      if ($urandom_range(3) == 0) begin
        send_byte(8'($urandom_range(255)), 1'b1);
        return;
      end
      send_byte(8'($urandom_range(255)), 1'b0);
    end else if ($urandom_range(1) == 1) begin
      send_text(header_text, 1'b0);
    end
    n = $urandom_range(1, 6);
    repeat (n - 1) begin
      send_token_body();
      send_byte(($urandom_range(1) == 1) ? csvtok_pkg::CH_COMMA : csvtok_pkg::CH_STAR, 1'b0);
    end
    send_token_body();
    case ($urandom_range(2))
      0:       send_byte(csvtok_pkg::CH_COMMA, 1'b1);
      1:       send_byte(digit_byte(), 1'b1);
      default: send_byte(8'($urandom_range(255)), 1'b1);
    endcase
  endtask

  // enough tokens in one message to saturate the index
  task automatic send_long_message();
    repeat (300) begin
      send_byte(digit_byte(), 1'b0);
      send_byte(csvtok_pkg::CH_COMMA, 1'b0);
    end
    send_byte(csvtok_pkg::CH_ZERO + 8'd8, 1'b0);
    send_byte(csvtok_pkg::CH_COMMA, 1'b1);
  endtask

  // hold the sender until every owed token has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (predictor.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int phase_gap[4];
    int phase_stall[4];
    int target;
    phase_gap   = '{0, 78, 0, 31};
    phase_stall = '{0, 0, 78, 31};
    predictor = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: header, extremes, empty token, broken headers, overflow, zero byte
    send_text("$RQ,-32768,,+32767*7;", 1'b1);
    send_text("$R", 1'b1);
    send_text("$RQ,", 1'b1);
    send_text("$", 1'b1);
    send_text("$RX1,", 1'b1);
    send_text(" 70000", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain_results();

    // random traffic under different idle patterns
    for (int p = 0; p < 4; p++) begin
      gap_pct   = phase_gap[p];
      stall_pct = phase_stall[p];
      if (p == 0) send_long_message();
      target = bytes_sent + 115;
      while (bytes_sent < target) send_random_message();
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (predictor.errors == 0 && predictor.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
